/* design/crsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crsa_pkg;

  // Largest ring the block may be configured for.
  localparam int unsigned MAX_SIZE = 65536;

  // Ring size limit; the size register is 17 bits wide, the result offset field 16 bits.
  localparam logic [16:0] SIZE_LIMIT = (MAX_SIZE < 65536) ? 17'(MAX_SIZE) : 17'd65536;

  // Register indexes of the configuration port.
  localparam logic REG_BUFFER_SIZE = 1'b0;

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_ADJUST  = 2'd2,
    CMD_GET     = 2'd3
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic        ok;
    logic [15:0] offset;
    logic [16:0] count;
    logic [16:0] used_bytes;
    logic [31:0] total_bytes;
  } res_t;

endpackage

`default_nettype wire

/* design/contiguous_ring_space_allocator_top.sv */
// A result is registered in the output register, or in the skid register while
// the output stalls. Throughput: one command per cycle unless the skid register
// is full; every command is one compare-and-add pass over the pointer registers.
// Reset (synchronous, rst high): ring size returns to its limit, the write and
// read offsets, the used count and the running total are cleared, the wrap mark
// returns to the last offset of the ring, and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_ring_space_allocator_top #(
  parameter int unsigned MAX_SIZE = crsa_pkg::MAX_SIZE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Command channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [16:0] amount,
  input  wire logic signed [17:0] delta,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic [15:0]      offset,
  output logic [16:0]      count,
  output logic [16:0]      used_bytes,
  output logic [31:0]      total_bytes
);

  // Ring size limit; the size register is 17 bits wide, the result offset field 16 bits.
  localparam logic [16:0] SIZE_LIMIT = (MAX_SIZE < 65536) ? 17'(MAX_SIZE) : 17'd65536;

  // Configuration and pointer state.
  logic [16:0] buffer_size;
  logic [16:0] write_pos;
  logic [16:0] read_pos;
  logic [16:0] wrap_mark;
  logic [16:0] used_count;
  logic [31:0] total_count;

  logic [16:0] write_pos_next;
  logic [16:0] read_pos_next;
  logic [16:0] wrap_mark_next;
  logic [16:0] used_count_next;
  logic [31:0] total_count_next;

  // Output register and skid register.
  crsa_pkg::res_t out_res;
  crsa_pkg::res_t skid_res;
  logic           skid_valid;
  crsa_pkg::res_t res_next;

  logic in_fire;
  logic cfg_write;
  logic [16:0] cfg_size;

  // Datapath temporaries.
  logic [16:0] size_m1;
  logic [17:0] reserve_sum;
  logic [17:0] reserve_end;
  logic signed [18:0] adjust_sum;
  logic [16:0] get_read;
  logic [16:0] get_wrap;
  logic [16:0] get_avail;
  logic [16:0] get_want;
  logic [16:0] get_count;

  // Register port: always ready, one register, decoded where paddr[2] is 0.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == crsa_pkg::REG_BUFFER_SIZE) ? {15'd0, buffer_size} : 32'd0;

  // Saturate the written size into 1..limit.
  always_comb begin
    cfg_size = pwdata[16:0];
    if (cfg_size == 17'd0) begin
      cfg_size = 17'd1;
    end else if (cfg_size > SIZE_LIMIT) begin
      cfg_size = SIZE_LIMIT;
    end
  end

  // A new command is held off only while the skid register is full.
  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;

  // Arithmetic used by the command cases.
  assign size_m1     = buffer_size - 17'd1;
  assign reserve_sum = {1'b0, used_count} + {1'b0, amount};
  assign reserve_end = {1'b0, write_pos} + {1'b0, amount};
  assign adjust_sum  = $signed({2'b00, used_count}) + 19'(delta);

  // A get first returns the read position to 0 when it sits on the wrap mark.
  assign get_read  = (wrap_mark == read_pos) ? 17'd0 : read_pos;
  assign get_wrap  = (wrap_mark == read_pos) ? size_m1 : wrap_mark;
  assign get_avail = (get_wrap >= get_read) ? (get_wrap - get_read) : 17'd0;
  assign get_want  = (used_count > amount) ? amount : used_count;
  assign get_count = (get_avail >= get_want) ? get_want : get_avail;

  // Next state and result of one command.
  always_comb begin
    write_pos_next   = write_pos;
    read_pos_next    = read_pos;
    wrap_mark_next   = wrap_mark;
    used_count_next  = used_count;
    total_count_next = total_count;
    res_next.ok      = 1'b0;
    res_next.offset  = 16'd0;
    res_next.count   = 17'd0;

    unique case (crsa_pkg::cmd_t'(cmd))
      crsa_pkg::CMD_CLEAR: begin
        write_pos_next   = 17'd0;
        read_pos_next    = 17'd0;
        wrap_mark_next   = size_m1;
        used_count_next  = 17'd0;
        total_count_next = 32'd0;
      end
      crsa_pkg::CMD_RESERVE: begin
        // Fails when the region does not fit in the free space.
        if (reserve_sum <= {1'b0, buffer_size}) begin
          res_next.ok = 1'b1;
          if (reserve_end < {1'b0, buffer_size}) begin
            res_next.offset = write_pos[15:0];
            write_pos_next  = reserve_end[16:0];
          end else begin
            // Not enough room before the last offset: wrap to the start.
            wrap_mark_next = write_pos;
            write_pos_next = amount;
          end
        end
      end
      crsa_pkg::CMD_ADJUST: begin
        if (adjust_sum < 19'sd0) begin
          used_count_next = 17'd0;
        end else if (adjust_sum > $signed({2'b00, buffer_size})) begin
          used_count_next = buffer_size;
        end else begin
          used_count_next = adjust_sum[16:0];
        end
        total_count_next = total_count + {{14{delta[17]}}, delta};
      end
      crsa_pkg::CMD_GET: begin
        read_pos_next  = get_read;
        wrap_mark_next = get_wrap;
        if (used_count != 17'd0) begin
          res_next.ok     = 1'b1;
          res_next.offset = get_read[15:0];
          res_next.count  = get_count;
          read_pos_next   = get_read + get_count;
        end
      end
    endcase

    res_next.used_bytes  = used_count_next;
    res_next.total_bytes = total_count_next;
  end

  // Pointer state; a size write clears everything as a clear command does.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= SIZE_LIMIT;
      write_pos   <= 17'd0;
      read_pos    <= 17'd0;
      wrap_mark   <= SIZE_LIMIT - 17'd1;
      used_count  <= 17'd0;
      total_count <= 32'd0;
    end else if (cfg_write && (paddr[2] == crsa_pkg::REG_BUFFER_SIZE)) begin
      buffer_size <= cfg_size;
      write_pos   <= 17'd0;
      read_pos    <= 17'd0;
      wrap_mark   <= cfg_size - 17'd1;
      used_count  <= 17'd0;
      total_count <= 32'd0;
    end else if (in_fire) begin
      write_pos   <= write_pos_next;
      read_pos    <= read_pos_next;
      wrap_mark   <= wrap_mark_next;
      used_count  <= used_count_next;
      total_count <= total_count_next;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_fire) begin
        out_res <= res_next;
      end
    end else if (in_fire) begin
      skid_res <= res_next;
    end
  end

  assign ok          = out_res.ok;
  assign offset      = out_res.offset;
  assign count       = out_res.count;
  assign used_bytes  = out_res.used_bytes;
  assign total_bytes = out_res.total_bytes;

  // The used count never exceeds the ring size.
  assert property (@(posedge clk) disable iff (rst) used_count <= buffer_size)
    else $error("used count exceeds ring size");

  // The write offset never passes the end of the ring.
  assert property (@(posedge clk) disable iff (rst) write_pos <= buffer_size)
    else $error("write offset beyond ring size");

  // The skid register only fills behind a waiting result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register holds a result while output is empty");

  // Every accepted command leaves a result pending in the next cycle.
  assert property (@(posedge clk) disable iff (rst) in_fire |=> out_valid)
    else $error("accepted command produced no result");

endmodule

`default_nettype wire
